FILE: rtl/core/assert_macros.svh
// assertion macros shared by the rtl in this folder
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property sampled on clk, off while reset is asserted
`define SVJR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent implies consequent on the next clock
`define SVJR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/svjr_pkg.sv
// types, codes and helpers for the servo joint ramp stepper
// no dependencies
`timescale 1ns / 1ps

package svjr_pkg;

	typedef logic [7:0] angle_t;
	typedef logic [2:0] servo_idx_t;

	localparam angle_t     MAX_ANGLE     = 8'd180;
	localparam angle_t     RESET_ANGLE   = 8'd90;
	localparam int         NUM_SERVOS    = 7;
	localparam servo_idx_t PARTNER_SERVO = 3'd2;
	localparam servo_idx_t COUPLED_JOINT = 3'd1;
	localparam servo_idx_t LAST_JOINT    = 3'd5;
	localparam servo_idx_t LAST_SERVO    = 3'd6;

	// request operation codes
	typedef enum logic [1:0] {
		OP_MOVE   = 2'd0,
		OP_TICK   = 2'd1,
		OP_PRESET = 2'd2
	} op_t;

	// configuration register indexes
	typedef enum logic [0:0] {
		CFG_STEP_SIZE      = 1'b0,
		CFG_COUPLED_OFFSET = 1'b1
	} cfg_idx_t;

	// joint to servo map, servo 2 is the partner of joint 1
	function automatic servo_idx_t joint_servo(input servo_idx_t joint);
		servo_idx_t sv;
		case (joint)
			3'd0:    sv = 3'd0;
			3'd1:    sv = 3'd1;
			3'd2:    sv = 3'd3;
			3'd3:    sv = 3'd4;
			3'd4:    sv = 3'd5;
			3'd5:    sv = 3'd6;
			default: sv = 3'd0;
		endcase
		return sv;
	endfunction

	// clamp an angle to the servo range
	function automatic angle_t sat_angle(input angle_t a);
		return (a > MAX_ANGLE) ? MAX_ANGLE : a;
	endfunction

endpackage

FILE: rtl/core/servo_joint_ramp_stepper_top.sv
// servo joint ramp stepper, top level
// depends on svjr_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
// Input channel (in_valid / in_stall) carries requests: op, joint, angle, invert.
// A move request latches a target for one joint and gives no result; each
// following tick request writes the next step angle of that joint's servo and
// gives one result; a preset request writes a servo position and gives one
// result. Requests that do not apply (busy, idle tick, bad index) give none.
// Output channel (out_valid / out_stall) carries one result per producing
// request, in request order.
// A request accepted into the input register passes on to the result register,
// from which its result drives the outputs.
// Throughput: one request per cycle while out_stall is low; each request reads and
// updates the ramp state in a single pass between the input and result registers.
// When the receiver stalls, the result register holds its result and the
// input register holds its request; in_stall rises once both are full.
// Configuration writes (cfg_wen, cfg_index, cfg_data) take effect at the next
// edge and are meant for idle periods only.
// Reset: step size 1, offset 0, every servo position 90, no move running,
// both registers empty.
module servo_joint_ramp_stepper_top
	import svjr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wen,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] op,
	input  logic [2:0] joint,
	input  logic [7:0] angle,
	input  logic       invert,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] servo_index,
	output logic [7:0] servo_angle,
	output logic       partner_valid,
	output logic [7:0] partner_angle,
	output logic       last_step
);

	// configuration registers
	angle_t step_size_q;
	angle_t coupled_offset_q;

	// ramp state
	angle_t     servo_position_q [NUM_SERVOS];
	logic       moving_q;
	servo_idx_t active_joint_q;
	angle_t     step_angle_q;
	angle_t     target_angle_q;
	logic       going_down_q;

	// input register
	logic       valid_s1;
	op_t        op_s1;
	servo_idx_t joint_s1;
	angle_t     angle_s1;
	logic       invert_s1;

	// result register
	logic       out_valid_q;
	servo_idx_t servo_index_q;
	angle_t     servo_angle_q;
	logic       partner_valid_q;
	angle_t     partner_angle_q;
	logic       last_step_q;

	// handshake
	logic out_free;
	logic adv_s1;
	logic in_take;

	assign out_free = !out_valid_q || !out_stall;
	assign adv_s1   = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	// operand conditioning
	angle_t     ang_sat;
	angle_t     offs;
	angle_t     size;
	angle_t     tgt_raw;
	angle_t     tgt_lim;
	angle_t     tgt;
	servo_idx_t move_servo;
	angle_t     move_start;
	servo_idx_t tick_servo;
	logic [8:0] dn_diff;
	logic [8:0] up_sum;
	logic [8:0] part_sum;
	angle_t     part_angle;
	logic       tick_last;

	assign ang_sat    = sat_angle(angle_s1);
	assign offs       = sat_angle(coupled_offset_q);
	assign size       = (step_size_q == 8'd0) ? 8'd1 : step_size_q;
	assign tgt_raw    = invert_s1 ? (MAX_ANGLE - ang_sat) : ang_sat;
	assign tgt_lim    = MAX_ANGLE - offs;
	assign tgt        = (joint_s1 == COUPLED_JOINT && tgt_raw > tgt_lim) ? tgt_lim : tgt_raw;
	assign move_servo = joint_servo(joint_s1);
	assign move_start = servo_position_q[move_servo];
	assign tick_servo = joint_servo(active_joint_q);

	// step arithmetic, borrow in bit 8 marks a step below zero
	assign dn_diff    = {1'b0, step_angle_q} - {1'b0, size};
	assign up_sum     = {1'b0, step_angle_q} + {1'b0, size};
	assign part_sum   = {1'b0, step_angle_q} + {1'b0, offs};
	assign part_angle = (part_sum > {1'b0, MAX_ANGLE}) ? MAX_ANGLE : part_sum[7:0];
	assign tick_last  = going_down_q ? (dn_diff[8] || dn_diff[7:0] < target_angle_q)
	                                 : (up_sum > {1'b0, target_angle_q});

	// request decode
	logic       res_valid;
	servo_idx_t res_index;
	angle_t     res_angle;
	logic       res_partner;
	angle_t     res_part_angle;
	logic       res_last;
	logic       do_move;
	logic       do_tick;
	logic       pos_we;
	servo_idx_t pos_idx;

	always_comb begin
		res_valid      = 1'b0;
		res_index      = '0;
		res_angle      = '0;
		res_partner    = 1'b0;
		res_part_angle = '0;
		res_last       = 1'b0;
		do_move        = 1'b0;
		do_tick        = 1'b0;
		pos_we         = 1'b0;
		pos_idx        = '0;
		case (op_s1)
			OP_MOVE: begin
				do_move = !moving_q && joint_s1 <= LAST_JOINT;
			end
			OP_TICK: begin
				if (moving_q) begin
					do_tick   = 1'b1;
					res_valid = 1'b1;
					res_index = tick_servo;
					res_angle = step_angle_q;
					res_last  = tick_last;
					pos_we    = 1'b1;
					pos_idx   = tick_servo;
					if (active_joint_q == COUPLED_JOINT) begin
						res_partner    = 1'b1;
						res_part_angle = part_angle;
					end
				end
			end
			OP_PRESET: begin
				if (!moving_q && joint_s1 <= LAST_SERVO) begin
					res_valid = 1'b1;
					res_index = joint_s1;
					res_angle = ang_sat;
					res_last  = 1'b1;
					pos_we    = 1'b1;
					pos_idx   = joint_s1;
				end
			end
			default: begin
			end
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_size_q      <= 8'd1;
			coupled_offset_q <= 8'd0;
		end else if (cfg_wen) begin
			case (cfg_idx_t'(cfg_index))
				CFG_STEP_SIZE:      step_size_q      <= cfg_data;
				CFG_COUPLED_OFFSET: coupled_offset_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_s1     <= op_t'(op);
			joint_s1  <= joint;
			angle_s1  <= angle;
			invert_s1 <= invert;
		end
	end

	// ramp state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			moving_q       <= 1'b0;
			active_joint_q <= '0;
			step_angle_q   <= '0;
			target_angle_q <= '0;
			going_down_q   <= 1'b0;
		end else if (adv_s1) begin
			if (do_move) begin
				moving_q       <= 1'b1;
				active_joint_q <= joint_s1;
				step_angle_q   <= move_start;
				target_angle_q <= tgt;
				going_down_q   <= tgt < move_start;
			end else if (do_tick) begin
				if (tick_last) begin
					moving_q <= 1'b0;
				end else begin
					step_angle_q <= going_down_q ? dn_diff[7:0] : up_sum[7:0];
				end
			end
		end
	end

	// servo positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SERVOS; i++) begin
				servo_position_q[i] <= RESET_ANGLE;
			end
		end else if (adv_s1) begin
			if (pos_we) begin
				servo_position_q[pos_idx] <= res_angle;
			end
			if (res_partner) begin
				servo_position_q[PARTNER_SERVO] <= res_part_angle;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= res_valid;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res_valid) begin
			servo_index_q   <= res_index;
			servo_angle_q   <= res_angle;
			partner_valid_q <= res_partner;
			partner_angle_q <= res_part_angle;
			last_step_q     <= res_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign servo_index   = servo_index_q;
	assign servo_angle   = servo_angle_q;
	assign partner_valid = partner_valid_q;
	assign partner_angle = partner_angle_q;
	assign last_step     = last_step_q;

	// checks
	`SVJR_ASSERT(a_stall_needs_req, !in_stall || valid_s1, "input stalled with empty register")
	`SVJR_ASSERT(a_partner_servo,
		!(out_valid_q && partner_valid_q) || (servo_index_q == COUPLED_JOINT),
		"partner write on a servo other than joint one")
	`SVJR_ASSERT(a_partner_above,
		!(out_valid_q && partner_valid_q) || (partner_angle_q >= servo_angle_q),
		"partner angle below joint angle")
	`SVJR_ASSERT(a_ramp_range,
		!moving_q || (step_angle_q <= MAX_ANGLE && target_angle_q <= MAX_ANGLE),
		"ramp angle out of range")
	`SVJR_ASSERT_NEXT(a_last_ends_move, adv_s1 && do_tick && tick_last, !moving_q,
		"move still running after its last step")

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// testbench for servo_joint_ramp_stepper_top: a directed table, then random ramps, checked
// against a behavioral ramp model or typed-in results on pinned table rows; depends on svjr_pkg and the top level

module testbench;
	import svjr_pkg::*;

	localparam int         PHASE_REQS   = 235;
	localparam int         NUM_PHASES   = 8;
	localparam int         QUIET_LIMIT  = 5000;
	localparam int         DRAIN_CYCLES = 4;
	localparam int         HOLD_CYCLES  = 80;
	localparam logic [1:0] OP_UNUSED    = 2'd3;
	// servo driven by each joint, three bits per joint, joint 0 lowest
	localparam logic [23:0] JOINT_MAP = {3'd0, 3'd0, 3'd6, 3'd5, 3'd4, 3'd3, 3'd1, 3'd0};

	typedef struct packed {
		servo_idx_t index;
		angle_t     ang;
		logic       partner;
		angle_t     partner_ang;
		logic       last;
	} servo_write_t;

	localparam servo_write_t NO_WRITE = '0;

	// one request of the directed table, with an optional typed-in result
	typedef struct packed {
		logic [1:0]   op;
		servo_idx_t   joint;
		angle_t       ang;
		logic         inv;
		logic         pinned;
		logic         pin_has;
		servo_write_t pin_res;
	} req_row_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cfg_wen   = 1'b0;
	logic [0:0] cfg_index = '0;
	logic [7:0] cfg_data  = '0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [1:0] op        = '0;
	logic [2:0] joint     = '0;
	logic [7:0] angle     = '0;
	logic       invert    = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [2:0] servo_index;
	logic [7:0] servo_angle;
	logic       partner_valid;
	logic [7:0] partner_angle;
	logic       last_step;

	// typed-in expectation that travels with the request on the input port
	logic         pin_valid = 1'b0;
	logic         pin_has   = 1'b0;
	servo_write_t pin_res   = '0;

	// ramp model state
	angle_t       servo_pos [NUM_SERVOS];
	logic         ramp_busy;
	servo_idx_t   ramp_joint;
	angle_t       ramp_angle;
	angle_t       ramp_target;
	logic         ramp_down;
	angle_t       step_reg;
	angle_t       offset_reg;
	int           ramp_len = 0;
	servo_write_t pending_writes [$];
	int           fail_count = 0;

	// receiver hold-off and calm stretch control
	int   hold_ticket = 0;
	int   hold_served = 0;
	int   hold_left   = 0;
	logic calm        = 1'b0;
	int   quiet_cycles = 0;

	// directed table, step size 90 and offset 30
	// columns: op, joint, angle, invert, pinned, has result, result
	req_row_t directed_rows [25] = '{
		'{OP_TICK,   3'd0, 8'd0,   1'b0, 1'b1, 1'b0, NO_WRITE},
		'{OP_PRESET, 3'd0, 8'd0,   1'b0, 1'b1, 1'b1, {3'd0, 8'd0, 1'b0, 8'd0, 1'b1}},
		'{OP_PRESET, 3'd6, 8'd255, 1'b0, 1'b1, 1'b1, {3'd6, 8'd180, 1'b0, 8'd0, 1'b1}},
		'{OP_PRESET, 3'd7, 8'd10,  1'b0, 1'b1, 1'b0, NO_WRITE},
		'{OP_UNUSED, 3'd7, 8'd255, 1'b1, 1'b1, 1'b0, NO_WRITE},
		'{OP_MOVE,   3'd0, 8'd180, 1'b0, 1'b1, 1'b0, NO_WRITE},
		'{OP_TICK,   3'd0, 8'd0,   1'b0, 1'b0, 1'b0, NO_WRITE},
		'{OP_MOVE,   3'd2, 8'd0,   1'b0, 1'b1, 1'b0, NO_WRITE},
		'{OP_PRESET, 3'd3, 8'd45,  1'b0, 1'b1, 1'b0, NO_WRITE},
		'{OP_TICK,   3'd0, 8'd0,   1'b0, 1'b0, 1'b0, NO_WRITE},
		'{OP_TICK,   3'd0, 8'd0,   1'b0, 1'b0, 1'b0, NO_WRITE},
		'{OP_MOVE,   3'd1, 8'd180, 1'b0, 1'b1, 1'b0, NO_WRITE},
		'{OP_TICK,   3'd0, 8'd0,   1'b0, 1'b0, 1'b0, NO_WRITE},
		'{OP_MOVE,   3'd5, 8'd180, 1'b1, 1'b1, 1'b0, NO_WRITE},
		'{OP_TICK,   3'd0, 8'd0,   1'b0, 1'b0, 1'b0, NO_WRITE},
		'{OP_TICK,   3'd0, 8'd0,   1'b0, 1'b0, 1'b0, NO_WRITE},
		'{OP_TICK,   3'd0, 8'd0,   1'b0, 1'b0, 1'b0, NO_WRITE},
		'{OP_MOVE,   3'd3, 8'd90,  1'b0, 1'b1, 1'b0, NO_WRITE},
		'{OP_TICK,   3'd0, 8'd0,   1'b0, 1'b1, 1'b1, {3'd4, 8'd90, 1'b0, 8'd0, 1'b1}},
		'{OP_MOVE,   3'd6, 8'd50,  1'b0, 1'b1, 1'b0, NO_WRITE},
		'{OP_MOVE,   3'd7, 8'd50,  1'b1, 1'b1, 1'b0, NO_WRITE},
		'{OP_TICK,   3'd0, 8'd0,   1'b0, 1'b1, 1'b0, NO_WRITE},
		'{OP_PRESET, 3'd1, 8'd180, 1'b0, 1'b1, 1'b1, {3'd1, 8'd180, 1'b0, 8'd0, 1'b1}},
		'{OP_MOVE,   3'd1, 8'd100, 1'b0, 1'b1, 1'b0, NO_WRITE},
		'{OP_TICK,   3'd0, 8'd0,   1'b0, 1'b1, 1'b1, {3'd1, 8'd180, 1'b1, 8'd180, 1'b1}}
	};

	servo_joint_ramp_stepper_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.joint         (joint),
		.angle         (angle),
		.invert        (invert),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.servo_index   (servo_index),
		.servo_angle   (servo_angle),
		.partner_valid (partner_valid),
		.partner_angle (partner_angle),
		.last_step     (last_step)
	);

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int clamp180(input int a);
		return (a > MAX_ANGLE) ? MAX_ANGLE : a;
	endfunction

	// advance the ramp model by one request, return the servo write it causes
	task automatic apply_request(input logic [1:0] rq_op, input servo_idx_t rq_joint,
			input angle_t rq_angle, input logic rq_inv,
			output logic produced, output servo_write_t w);
		int a, offs, sz, tgt, cur;
		logic fin;
		servo_idx_t sv;
		produced = 1'b0;
		w = NO_WRITE;
		a = clamp180(int'(rq_angle));
		offs = clamp180(int'(offset_reg));
		sz = (step_reg == 0) ? 1 : int'(step_reg);
		case (rq_op)
			OP_MOVE: begin
				if (!ramp_busy && rq_joint <= LAST_JOINT) begin
					tgt = rq_inv ? MAX_ANGLE - a : a;
					if (rq_joint == COUPLED_JOINT && tgt > MAX_ANGLE - offs)
						tgt = MAX_ANGLE - offs;
					ramp_joint = rq_joint;
					ramp_angle = servo_pos[JOINT_MAP[rq_joint * 3 +: 3]];
					ramp_target = angle_t'(tgt);
					ramp_down = tgt < ramp_angle;
					ramp_busy = 1'b1;
					// number of ticks this ramp will take, used to pace the stimulus
					cur = int'(ramp_angle);
					ramp_len = 1;
					fin = 1'b0;
					while (!fin) begin
						if (ramp_down)
							fin = (cur < sz) || (cur - sz < tgt);
						else
							fin = cur + sz > tgt;
						if (!fin) begin
							cur = ramp_down ? cur - sz : cur + sz;
							ramp_len++;
						end
					end
				end
			end
			OP_TICK: begin
				if (ramp_busy) begin
					sv = JOINT_MAP[ramp_joint * 3 +: 3];
					cur = int'(ramp_angle);
					tgt = int'(ramp_target);
					if (ramp_down)
						fin = (cur < sz) || (cur - sz < tgt);
					else
						fin = cur + sz > tgt;
					if (!fin)
						ramp_angle = angle_t'(ramp_down ? cur - sz : cur + sz);
					servo_pos[sv] = angle_t'(cur);
					w.index = sv;
					w.ang = angle_t'(cur);
					w.last = fin;
					// coupled joint drags its partner servo along
					if (ramp_joint == COUPLED_JOINT) begin
						w.partner = 1'b1;
						w.partner_ang = angle_t'(clamp180(cur + offs));
						servo_pos[PARTNER_SERVO] = w.partner_ang;
					end
					if (fin)
						ramp_busy = 1'b0;
					produced = 1'b1;
				end
			end
			OP_PRESET: begin
				if (!ramp_busy && rq_joint <= LAST_SERVO) begin
					servo_pos[rq_joint] = angle_t'(a);
					w.index = rq_joint;
					w.ang = angle_t'(a);
					w.last = 1'b1;
					produced = 1'b1;
				end
			end
			default: ;
		endcase
	endtask

	// predict on accepted requests, check accepted results
	always @(posedge clk) begin : check_writes
		logic produced;
		servo_write_t w, got, want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_SERVOS; i++)
				servo_pos[i] = RESET_ANGLE;
			ramp_busy = 1'b0;
			ramp_joint = '0;
			ramp_angle = '0;
			ramp_target = '0;
			ramp_down = 1'b0;
			step_reg = 8'd1;
			offset_reg = 8'd0;
			pending_writes.delete();
		end else begin
			if (cfg_wen) begin
				case (cfg_idx_t'(cfg_index))
					CFG_STEP_SIZE:      step_reg = cfg_data;
					CFG_COUPLED_OFFSET: offset_reg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				apply_request(op, joint, angle, invert, produced, w);
				if (pin_valid) begin
					produced = pin_has;
					w = pin_res;
				end
				if (produced)
					pending_writes.push_back(w);
			end
			if (out_valid && !out_stall) begin
				got = {servo_index, servo_angle, partner_valid, partner_angle, last_step};
				if (pending_writes.size() == 0) begin
					fail_count++;
					if (fail_count <= 40)
						$display("%0t: unexpected servo write: servo %0d angle %0d partner %0b/%0d last %0b",
							$realtime, got.index, got.ang, got.partner, got.partner_ang, got.last);
				end else begin
					want = pending_writes.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 40)
							$display({"%0t: servo write mismatch: expected servo %0d angle %0d ",
								"partner %0b/%0d last %0b, got servo %0d angle %0d partner %0b/%0d last %0b"},
								$realtime, want.index, want.ang, want.partner, want.partner_ang,
								want.last, got.index, got.ang, got.partner, got.partner_ang, got.last);
					end
				end
			end
		end
	end

	// receiver: random stalls, long hold-off on request, none while calm
	always @(posedge clk) begin
		if (hold_ticket != hold_served) begin
			hold_served <= hold_ticket;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < 25);
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (!arst_n || cfg_wen || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("** servo_joint_ramp_stepper_top: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// offer one request, with a random gap first, and wait until it is taken
	task automatic send_request(input logic [1:0] rq_op, input servo_idx_t rq_joint,
			input angle_t rq_angle, input logic rq_inv,
			input logic pinned, input logic has, input servo_write_t res);
		int gap;
		// each cycle before the request idles with a one in four chance
		gap = 0;
		while (!calm && $urandom_range(99) < 25)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= rq_op;
		joint <= rq_joint;
		angle <= rq_angle;
		invert <= rq_inv;
		pin_valid <= pinned;
		pin_has <= has;
		pin_res <= res;
		do @(posedge clk); while (in_stall);
	endtask

	// stop offering and wait until every expected write has come back
	task automatic drain_writes();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_writes.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write both registers on back-to-back cycles
	task automatic set_ramp_config(input angle_t step, input angle_t offs);
		cfg_wen <= 1'b1;
		cfg_index <= CFG_STEP_SIZE;
		cfg_data <= step;
		@(posedge clk);
		cfg_index <= CFG_COUPLED_OFFSET;
		cfg_data <= offs;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	// stimulus
	initial begin
		int sent, n;
		logic hold_asked;
		angle_t step, offs, a;
		hold_asked = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		set_ramp_config(8'd90, 8'd30);
		foreach (directed_rows[i])
			send_request(directed_rows[i].op, directed_rows[i].joint, directed_rows[i].ang,
				directed_rows[i].inv, directed_rows[i].pinned, directed_rows[i].pin_has,
				directed_rows[i].pin_res);
		drain_writes();

		// random phases, each with its own register setting
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: begin step = 8'd1;   offs = 8'd0;   end
				1: begin step = 8'd180; offs = 8'd180; end
				2: begin step = 8'd0;   offs = 8'd255; end
				3: begin step = 8'd255; offs = 8'd7;   end
				default: begin
					step = angle_t'($urandom_range(2, 40));
					offs = angle_t'($urandom_range(0, 200));
				end
			endcase
			set_ramp_config(step, offs);
			calm = (ph == 3);
			sent = 0;
			while (sent < PHASE_REQS) begin
				if (ph == 4 && !hold_asked && sent >= 40) begin
					hold_ticket++;
					hold_asked = 1'b1;
				end
				if ($urandom_range(99) < 80) begin
					// well-formed ramp: a move, then ticks up to its end or cut short
					a = ($urandom_range(9) == 0) ? angle_t'($urandom_range(181, 255))
						: angle_t'($urandom_range(0, 180));
					ramp_len = 0;
					send_request(OP_MOVE, servo_idx_t'($urandom_range(0, LAST_JOINT)), a,
						1'($urandom_range(1)), 1'b0, 1'b0, NO_WRITE);
					send_request(OP_TICK, servo_idx_t'($urandom_range(7)),
						angle_t'($urandom_range(255)), 1'($urandom_range(1)),
						1'b0, 1'b0, NO_WRITE);
					n = (ramp_len < 1) ? 1 : ramp_len;
					if ($urandom_range(99) < 15)
						n = $urandom_range(1, n);
					repeat (n - 1)
						send_request(OP_TICK, servo_idx_t'($urandom_range(7)),
							angle_t'($urandom_range(255)), 1'($urandom_range(1)),
							1'b0, 1'b0, NO_WRITE);
					sent += n + 1;
				end else begin
					// noise: any operation, index and angle
					send_request(2'($urandom_range(3)), servo_idx_t'($urandom_range(7)),
						angle_t'($urandom_range(255)), 1'($urandom_range(1)),
						1'b0, 1'b0, NO_WRITE);
					sent++;
				end
			end
			drain_writes();
		end
		calm = 1'b0;

		if (fail_count == 0)
			$display("** servo_joint_ramp_stepper_top: PASSED **");
		else
			$display("** servo_joint_ramp_stepper_top: FAILED **");
		$finish;
	end

endmodule
